// ===== src/tcrig_pkg.sv =====
package tcrig_pkg;

   localparam int unsigned WordWidth = 64;
   localparam int unsigned ShiftWidth = 6;
   localparam int unsigned CountWidth = 7;
   localparam int unsigned CsrIndexWidth = 3;

   localparam logic [WordWidth-1:0] RNG_SEED = 64'h5248_c856_1600_f46d;

   typedef enum logic {
      OP_GENERATE = 1'b0,
      OP_REFRESH  = 1'b1
   } op_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_TIME_SHIFT   = 3'd0,
      CSR_COUNTER_BITS = 3'd1,
      CSR_COUNT_POS    = 3'd2,
      CSR_RANDOM_BITS  = 3'd3,
      CSR_RAND_POS     = 3'd4,
      CSR_NODE_ID      = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [ShiftWidth-1:0] time_shift;
      logic [CountWidth-1:0] counter_bits;
      logic [ShiftWidth-1:0] count_pos;
      logic [CountWidth-1:0] random_bits;
      logic [ShiftWidth-1:0] rand_pos;
      logic [WordWidth-1:0]  node_id;
   } cfg_type;

   function automatic logic [WordWidth-1:0] low_mask(input logic [CountWidth-1:0] bits);
      logic [WordWidth-1:0] mask;
      if (bits >= CountWidth'(WordWidth)) begin
         mask = '1;
      end else begin
         mask = (WordWidth'(1) << bits[ShiftWidth-1:0]) - WordWidth'(1);
      end
      return mask;
   endfunction

endpackage

// ===== src/time_counter_random_id_generator.sv =====
// Unique 64-bit identifier generator: timestamp, sequence count, node id and
// xorshift random bits ORed together.
// Request channel (req_valid/req_ready): req_operation selects generate or a
// forced timestamp refresh on the next generate; req_time_now is the time in
// nanoseconds for a generate. A refresh item produces no result.
// Result channel (rsp_valid/rsp_ready): rsp_unique_id, one item per generate.
// Config channel (csr_valid/csr_ready, csr_index, csr_data): always ready;
// write only while no item is in flight.
// Path: an accepted generate item waits in the input register and is loaded
// into the result register, which raises rsp_valid, once that register is empty
// or its result is taken.
// Throughput: one item per cycle while results are taken; the input and result
// registers form a two-stage pipe with the whole update combinational between.
// When the receiver stalls, the result is held, refresh items still pass, and a
// generate item in the input register drops req_ready until rsp_ready returns.
// Reset: config registers clear, the counter and stored time clear, the random
// state takes its seed, and the first generate takes a fresh timestamp.
module time_counter_random_id_generator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_operation,
   input  logic [tcrig_pkg::WordWidth-1:0]       req_time_now,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [tcrig_pkg::WordWidth-1:0]       rsp_unique_id,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tcrig_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [tcrig_pkg::WordWidth-1:0]       csr_data
);
   import tcrig_pkg::*;

   cfg_type              cfg;
   logic                 s1_valid_ff, s1_valid_in;
   op_type               s1_op_ff;
   logic [WordWidth-1:0] s1_time_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WordWidth-1:0] rsp_id_ff;
   logic [WordWidth-1:0] core_id;
   logic                 fire;
   logic                 load;
   logic                 req_take;

   tcrig_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tcrig_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .fire      (fire),
      .operation (s1_op_ff),
      .time_now  (s1_time_ff),
      .unique_id (core_id)
   );

   assign fire = s1_valid_ff && (!rsp_valid_ff || rsp_ready || (s1_op_ff == OP_REFRESH));
   assign load = fire && (s1_op_ff == OP_GENERATE);
   assign req_ready = !s1_valid_ff || fire;
   assign req_take = req_valid && req_ready;
   assign s1_valid_in = req_take || (s1_valid_ff && !fire);
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_unique_id = rsp_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff <= op_type'(req_operation);
         s1_time_ff <= req_time_now;
      end
      if (load) begin
         rsp_id_ff <= core_id;
      end
   end

   a_generate_gives_result: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("generate item did not reach result register");

   a_refresh_no_result: assert property (@(posedge clock) disable iff (reset)
      (fire && (s1_op_ff == OP_REFRESH) && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("refresh item produced a result");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ready
                      && (s1_op_ff == OP_GENERATE)))
      else $error("input stalled without a blocked result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(rsp_id_ff))
      else $error("held result overwritten");

endmodule

// ===== src/tcrig_csr.sv =====
module tcrig_csr (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [tcrig_pkg::CsrIndexWidth-1:0]       csr_index,
   input  logic [tcrig_pkg::WordWidth-1:0]           csr_data,
   output tcrig_pkg::cfg_type                        cfg
);
   import tcrig_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_ready = 1'b1;
   assign wr_en = csr_valid && csr_ready;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_index)
            CSR_TIME_SHIFT:   cfg_in.time_shift = csr_data[ShiftWidth-1:0];
            CSR_COUNTER_BITS: cfg_in.counter_bits = csr_data[CountWidth-1:0];
            CSR_COUNT_POS:    cfg_in.count_pos = csr_data[ShiftWidth-1:0];
            CSR_RANDOM_BITS:  cfg_in.random_bits = csr_data[CountWidth-1:0];
            CSR_RAND_POS:     cfg_in.rand_pos = csr_data[ShiftWidth-1:0];
            CSR_NODE_ID:      cfg_in.node_id = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/tcrig_core.sv =====
module tcrig_core (
   input  logic                              clock,
   input  logic                              reset,
   input  tcrig_pkg::cfg_type                cfg,
   input  logic                              fire,
   input  tcrig_pkg::op_type                 operation,
   input  logic [tcrig_pkg::WordWidth-1:0]   time_now,
   output logic [tcrig_pkg::WordWidth-1:0]   unique_id
);
   import tcrig_pkg::*;

   logic [WordWidth-1:0] seq_ff, seq_in;
   logic                 pending_ff, pending_in;
   logic [WordWidth-1:0] stored_ff, stored_in;
   logic [WordWidth-1:0] rng_ff, rng_in;

   logic [WordWidth-1:0] cmax;
   logic                 refresh;
   logic [WordWidth-1:0] fresh;
   logic [WordWidth-1:0] bump;
   logic [WordWidth-1:0] stored_nx;
   logic [WordWidth-1:0] seq_nx;
   logic [WordWidth-1:0] x0, x1, x2;

   always_comb begin
      cmax = low_mask(cfg.counter_bits);
      refresh = pending_ff || (seq_ff >= cmax);
      fresh = time_now << cfg.time_shift;
      bump = WordWidth'(1) << cfg.time_shift;
      stored_nx = stored_ff;
      seq_nx = seq_ff + WordWidth'(1);
      if (refresh) begin
         seq_nx = '0;
         if ((stored_ff != '0) && (stored_ff >= fresh)) begin
            stored_nx = stored_ff + bump;
         end else begin
            stored_nx = fresh;
         end
      end
      // xorshift64 step
      x0 = rng_ff ^ (rng_ff << 13);
      x1 = x0 ^ (x0 >> 7);
      x2 = x1 ^ (x1 << 17);
      unique_id = stored_nx | (seq_nx << cfg.count_pos) | cfg.node_id
                | ((x2 & low_mask(cfg.random_bits)) << cfg.rand_pos);
   end

   always_comb begin
      seq_in = seq_ff;
      pending_in = pending_ff;
      stored_in = stored_ff;
      rng_in = rng_ff;
      if (fire) begin
         unique case (operation)
            OP_REFRESH: begin
               pending_in = 1'b1;
            end
            OP_GENERATE: begin
               pending_in = 1'b0;
               seq_in = seq_nx;
               stored_in = stored_nx;
               rng_in = x2;
            end
            default: pending_in = pending_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= '0;
         pending_ff <= 1'b1;
         stored_ff <= '0;
         rng_ff <= RNG_SEED;
      end else begin
         seq_ff <= seq_in;
         pending_ff <= pending_in;
         stored_ff <= stored_in;
         rng_ff <= rng_in;
      end
   end

endmodule

// ===== tb/sv/time_counter_random_id_generator_tb.sv =====
module time_counter_random_id_generator_tb;
   import tcrig_pkg::*;

   localparam int unsigned QuietLimit = 2000;
   localparam int unsigned PhaseItems = 92;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_operation = OP_GENERATE;
   logic [WordWidth-1:0] req_time_now = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b1;
   logic [WordWidth-1:0] rsp_unique_id;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = CSR_TIME_SHIFT;
   logic [WordWidth-1:0] csr_data = '0;

   // id generator copy
   cfg_type model_cfg;
   logic [WordWidth-1:0] seq_count;
   logic refresh_due;
   logic [WordWidth-1:0] stamp;
   logic [WordWidth-1:0] rng_word;
   logic [WordWidth-1:0] expected_ids[$];

   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;
   int unsigned ready_hold = 0;
   bit steady = 1'b0;
   logic [WordWidth-1:0] wall_ns;

   time_counter_random_id_generator uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_time_now(req_time_now),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_unique_id(rsp_unique_id),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   function automatic logic [WordWidth-1:0] field_mask(input logic [CountWidth-1:0] width);
      if (width >= 7'd64) return '1;
      return (64'd1 << width) - 64'd1;
   endfunction

   task automatic predict_id(input op_type op, input logic [WordWidth-1:0] now);
      logic [WordWidth-1:0] top;
      logic [WordWidth-1:0] fresh;
      logic [WordWidth-1:0] rnd;
      logic [WordWidth-1:0] id;
      if (op == OP_REFRESH) begin
         refresh_due = 1'b1;
      end else begin
         top = field_mask(model_cfg.counter_bits);
         if (refresh_due || seq_count >= top) begin
            refresh_due = 1'b0;
            seq_count = '0;
            fresh = now << model_cfg.time_shift;
            if (stamp != '0 && stamp >= fresh) begin
               stamp = stamp + (64'd1 << model_cfg.time_shift);
            end else begin
               stamp = fresh;
            end
         end else begin
            seq_count = seq_count + 64'd1;
         end
         rng_word = rng_word ^ (rng_word << 13);
         rng_word = rng_word ^ (rng_word >> 7);
         rng_word = rng_word ^ (rng_word << 17);
         rnd = rng_word & field_mask(model_cfg.random_bits);
         id = stamp | (seq_count << model_cfg.count_pos) | model_cfg.node_id
            | (rnd << model_cfg.rand_pos);
         expected_ids.push_back(id);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         model_cfg = '0;
         seq_count = '0;
         refresh_due = 1'b1;
         stamp = '0;
         rng_word = RNG_SEED;
         expected_ids.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_ids.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual %h", $time,
                  rsp_unique_id);
               mismatches++;
            end else if (rsp_unique_id !== expected_ids[0]) begin
               $display("%0t: unique_id mismatch, expected %h, actual %h", $time,
                  expected_ids[0], rsp_unique_id);
               mismatches++;
               void'(expected_ids.pop_front());
            end else begin
               void'(expected_ids.pop_front());
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_TIME_SHIFT: model_cfg.time_shift = csr_data[ShiftWidth-1:0];
               CSR_COUNTER_BITS: model_cfg.counter_bits = csr_data[CountWidth-1:0];
               CSR_COUNT_POS: model_cfg.count_pos = csr_data[ShiftWidth-1:0];
               CSR_RANDOM_BITS: model_cfg.random_bits = csr_data[CountWidth-1:0];
               CSR_RAND_POS: model_cfg.rand_pos = csr_data[ShiftWidth-1:0];
               CSR_NODE_ID: model_cfg.node_id = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            predict_id(op_type'(req_operation), req_time_now);
         end
      end
   end

   always @(posedge clock) begin : rsp_stall
      int unsigned pick;
      if (reset || steady) begin
         rsp_ready <= 1'b1;
      end else if (ready_hold != 0) begin
         ready_hold = ready_hold - 1;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            rsp_ready <= 1'b1;
            ready_hold = $urandom_range(0, 12);
         end else if (pick < 95) begin
            rsp_ready <= 1'b0;
            ready_hold = $urandom_range(0, 3);
         end else begin
            rsp_ready <= 1'b0;
            ready_hold = $urandom_range(10, 40);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
            || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QuietLimit) begin
            $display("time_counter_random_id_generator_tb NOT OK");
            $finish;
         end
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (steady || pick < 50) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_item(input op_type op, input logic [WordWidth-1:0] now);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_time_now <= now;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_ids.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_csr(input csr_index_type index, input logic [WordWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_config(input logic [WordWidth-1:0] ts, cb, cs, rb, rs, node);
      put_csr(CSR_TIME_SHIFT, ts);
      put_csr(CSR_COUNTER_BITS, cb);
      put_csr(CSR_COUNT_POS, cs);
      put_csr(CSR_RANDOM_BITS, rb);
      put_csr(CSR_RAND_POS, rs);
      put_csr(CSR_NODE_ID, node);
      csr_valid <= 1'b0;
   endtask

   // reset config: first stamp, zero time, bump on repeat, refresh, max time
   task automatic test_default_config();
      send_item(OP_GENERATE, 64'd0);
      send_item(OP_GENERATE, 64'd10);
      send_item(OP_GENERATE, 64'd10);
      send_item(OP_REFRESH, 64'd0);
      send_item(OP_GENERATE, 64'd5);
      send_item(OP_GENERATE, '1);
      wait_idle();
   endtask

   // counter wraps past its maximum, time going backwards, shifted time wraps
   task automatic test_counter_wrap_and_bump();
      load_config(64'd20, 64'd3, 64'd40, 64'd8, 64'd48, 64'h0000_0000_0000_0abc);
      repeat (8) send_item(OP_GENERATE, 64'd100);
      send_item(OP_REFRESH, '1);
      send_item(OP_GENERATE, 64'd50);
      send_item(OP_GENERATE, 64'hffff_ffff_ffff_ffff);
      wait_idle();
   endtask

   // counter left above a smaller maximum forces a refresh
   task automatic test_counter_shrink();
      load_config(64'd0, 64'd4, 64'd8, 64'd0, 64'd0, 64'd0);
      repeat (5) send_item(OP_GENERATE, 64'd7);
      wait_idle();
      load_config(64'd0, 64'd2, 64'd8, 64'd0, 64'd0, 64'd0);
      repeat (2) send_item(OP_GENERATE, 64'd7);
      wait_idle();
   endtask

   // top shifts, full and oversized widths, register data with high junk
   task automatic test_wide_fields();
      load_config('1, 64'd64, 64'd63, 64'd127, 64'd63, 64'd0);
      send_item(OP_GENERATE, 64'd1);
      send_item(OP_GENERATE, 64'd1);
      send_item(OP_GENERATE, '1);
      wait_idle();
      load_config(64'd0, 64'hffff_ffff_ffff_ff64, 64'd0, 64'd64, 64'd0, '1);
      send_item(OP_GENERATE, 64'h8000_0000_0000_0000);
      wait_idle();
   endtask

   function automatic logic [WordWidth-1:0] with_junk(input logic [WordWidth-1:0] value);
      logic [WordWidth-1:0] junk;
      junk = {$urandom, $urandom};
      if ($urandom_range(0, 1) == 0) return value;
      return {junk[63:7], value[6:0]};
   endfunction

   function automatic logic [WordWidth-1:0] pick_width();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return WordWidth'($urandom_range(0, 6));
      if (pick < 85) return WordWidth'($urandom_range(7, 20));
      return WordWidth'($urandom_range(60, 127));
   endfunction

   function automatic logic [WordWidth-1:0] next_time(input logic [WordWidth-1:0] last);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) return last + WordWidth'($urandom_range(0, 3));
      if (pick < 75) return last;
      if (pick < 85) return last - WordWidth'($urandom_range(1, 5));
      if (pick < 95) return {$urandom, $urandom};
      return '0;
   endfunction

   task automatic test_random_traffic();
      logic [WordWidth-1:0] node;
      op_type op;
      for (int phase = 0; phase < 6; phase++) begin
         steady = (phase == 0);
         node = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         if (phase == 0) begin
            load_config(64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
         end else if (phase == 1) begin
            load_config(with_junk(64'd63), with_junk(64'd127), with_junk(64'd63),
               with_junk(64'd127), with_junk(64'd63), node);
         end else begin
            load_config(with_junk(WordWidth'($urandom_range(0, 63))),
               with_junk(pick_width()),
               with_junk(WordWidth'($urandom_range(0, 63))),
               with_junk(pick_width()),
               with_junk(WordWidth'($urandom_range(0, 63))), node);
         end
         wall_ns = {$urandom, $urandom} >> $urandom_range(0, 63);
         for (int i = 0; i < PhaseItems; i++) begin
            op = ($urandom_range(0, 99) < 12) ? OP_REFRESH : OP_GENERATE;
            wall_ns = next_time(wall_ns);
            send_item(op, wall_ns);
            if (i == PhaseItems / 2 && phase % 2 == 1) begin
               wait_idle();
            end
         end
         wait_idle();
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_default_config();
      test_counter_wrap_and_bump();
      test_counter_shrink();
      test_wide_fields();
      test_random_traffic();
      wait_idle();
      if (mismatches == 0 && expected_ids.size() == 0) begin
         $display("time_counter_random_id_generator_tb OK");
      end else begin
         $display("time_counter_random_id_generator_tb NOT OK");
      end
      $finish;
   end

endmodule
